@@ src/gpat_pkg.sv @@
// Shared constants and types for the guard page allocation table.
package gpat_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int ADDR_BITS_DEF = 48;

	localparam int PAGE_W   = 31;
	localparam int SIZE_W   = 32;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;
	localparam int SIDE_W   = 2;
	localparam int COUNT_W  = 7;

	localparam logic [PAGE_W-1:0] PAGE_RESET = PAGE_W'(4096);

	localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_GUARD  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ULOOK  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_B2U    = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
	localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

	typedef struct packed {
		logic                vld;
		logic                hit;
		logic                last;
		logic [SIDE_W-1:0]   side;
	} match_t;

endpackage

@@ src/gpat_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gpat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/gpat_match.sv @@
// Match stage: registers one scanned entry and decides whether it satisfies the operation.
module gpat_match
	import gpat_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         flush,
	input  logic [FUNC_W-1:0]                            func,
	input  logic [ADDR_BITS-1:0]                         user_address,
	input  logic [ADDR_BITS-1:0]                         fault_address,
	input  logic [PAGE_W-1:0]                            page,
	input  logic [PAGE_W:0]                              page2,
	input  logic [PAGE_W+1:0]                            page3,
	input  logic                                         vld_s1,
	input  logic                                         last_s1,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_s1,
	input  logic [2*ADDR_BITS+SIZE_W:0]                  entry_s1,
	output match_t                                       mres,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_s2,
	output logic [ADDR_BITS-1:0]                         base_s2,
	output logic [ADDR_BITS-1:0]                         user_s2,
	output logic [SIZE_W-1:0]                            size_s2
);

	localparam int XW = ADDR_BITS + 1;
	localparam int RW = 2 * ADDR_BITS + SIZE_W + 1;

	logic                 ev_s1;
	logic [ADDR_BITS-1:0] base_s1;
	logic [ADDR_BITS-1:0] user_s1;
	logic [SIZE_W-1:0]    size_s1;

	logic                 vld_s2;
	logic                 last_s2;
	logic                 ev_s2;
	logic                 ge_s2;
	logic                 umatch_s2;
	logic [ADDR_BITS-1:0] d_s2;

	logic left_hit;
	logic right_hit;
	logic hit;

	assign base_s1 = entry_s1[ADDR_BITS-1:0];
	assign user_s1 = entry_s1[2*ADDR_BITS-1:ADDR_BITS];
	assign size_s1 = entry_s1[2*ADDR_BITS+SIZE_W-1:2*ADDR_BITS];
	assign ev_s1   = entry_s1[RW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && !flush;
		end
	end

	always_ff @(posedge clk) begin
		last_s2   <= last_s1;
		slot_s2   <= slot_s1;
		base_s2   <= base_s1;
		user_s2   <= user_s1;
		size_s2   <= size_s1;
		ev_s2     <= ev_s1;
		ge_s2     <= fault_address >= base_s1;
		umatch_s2 <= user_s1 == user_address;
		d_s2      <= fault_address - base_s1;
	end

	assign left_hit  = ge_s2 && (XW'(d_s2) < XW'(page));
	assign right_hit = ge_s2 && (XW'(d_s2) >= XW'(page2)) && (XW'(d_s2) < XW'(page3));

	always_comb begin
		hit       = 1'b0;
		mres.side = SIDE_NONE;
		unique case (func)
			FUNC_ADD: begin
				hit = !ev_s2;
			end
			FUNC_REMOVE, FUNC_ULOOK: begin
				hit = ev_s2 && umatch_s2;
			end
			FUNC_GUARD: begin
				hit = ev_s2 && (left_hit || right_hit);
				if (ev_s2 && left_hit) begin
					mres.side = SIDE_LEFT;
				end else if (ev_s2 && right_hit) begin
					mres.side = SIDE_RIGHT;
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		mres.vld  = vld_s2;
		mres.hit  = hit;
		mres.last = last_s2;
	end

endmodule

@@ src/guard_page_allocation_table_core.sv @@
// Top level of the guard page allocation table: control, record memory and result register.
//
// Records live in one RAM, one word per slot (valid mark, base, user address, size). After
// reset the block runs a clearing pass over every RAM slot and holds in_stall high
// meanwhile; page-size writes are taken at any time. Add, remove, guard lookup and user
// lookup scan the RAM one slot per cycle from slot 0 through a read stage and a compare
// stage; a scan stops at the first hit or after the last slot. Base-to-user and unknown
// codes do not touch the RAM. One item is worked on at a time; the next input beat is
// taken as soon as the result is in the output register, even while that beat is still
// stalled.
module guard_page_allocation_table_core
	import gpat_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [PAGE_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FUNC_W-1:0]     func,
	input  logic [ADDR_BITS-1:0]  block_base,
	input  logic [ADDR_BITS-1:0]  user_address,
	input  logic [SIZE_W-1:0]     request_size,
	input  logic [ADDR_BITS-1:0]  fault_address,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_W-1:0]     slot,
	output logic [SIDE_W-1:0]     guard_side,
	output logic [ADDR_BITS-1:0]  record_base,
	output logic [ADDR_BITS-1:0]  record_user,
	output logic [SIZE_W-1:0]     record_size,
	output logic [ADDR_BITS:0]    computed_address,
	output logic [COUNT_W-1:0]    live_count
);

	localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNTW = $clog2(SLOTS + 1);
	localparam int RW   = 2 * ADDR_BITS + SIZE_W + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [IW-1:0]        idx_q;
	logic                 issue_q;
	logic                 vld_s1;
	logic                 last_s1;
	logic [IW-1:0]        slot_s1;
	logic [CNTW-1:0]      count_q;
	logic [PAGE_W-1:0]    page_q;
	logic                 out_valid_q;

	logic [FUNC_W-1:0]    func_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [ADDR_BITS-1:0] ua_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ADDR_BITS-1:0] fa_q;
	logic [PAGE_W:0]      page2_q;
	logic [PAGE_W+1:0]    page3_q;

	logic [STATUS_W-1:0]  res_status_q;
	logic [IW-1:0]        res_slot_q;
	logic [SIDE_W-1:0]    res_side_q;
	logic [ADDR_BITS-1:0] res_base_q;
	logic [ADDR_BITS-1:0] res_user_q;
	logic [SIZE_W-1:0]    res_size_q;
	logic [ADDR_BITS:0]   res_comp_q;

	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SIDE_W-1:0]    side_q;
	logic [ADDR_BITS-1:0] rbase_q;
	logic [ADDR_BITS-1:0] ruser_q;
	logic [SIZE_W-1:0]    rsize_q;
	logic [ADDR_BITS:0]   comp_q;
	logic [COUNT_W-1:0]   live_q;

	logic                 in_acc;
	logic                 issue;
	logic                 finish;
	logic                 is_add;
	logic                 is_rem;
	logic                 scan_func;
	logic                 out_load;
	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	logic [RW-1:0]        ram_wdata;
	logic [RW-1:0]        entry_s1;

	match_t               mres;
	logic [IW-1:0]        slot_s2;
	logic [ADDR_BITS-1:0] base_s2;
	logic [ADDR_BITS-1:0] user_s2;
	logic [SIZE_W-1:0]    size_s2;

	assign cfg_ready = 1'b1;
	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign scan_func = (func == FUNC_ADD) || (func == FUNC_REMOVE) || (func == FUNC_GUARD)
		|| (func == FUNC_ULOOK);
	assign is_add    = func_q == FUNC_ADD;
	assign is_rem    = func_q == FUNC_REMOVE;
	assign issue     = (state_q == ST_SCAN) && issue_q;
	assign finish    = (state_q == ST_SCAN) && mres.vld && (mres.hit || mres.last);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (finish && mres.hit && is_add) begin
			ram_we    = 1'b1;
			ram_waddr = slot_s2;
			ram_wdata = {1'b1, size_q, ua_q, base_q};
		end else if (finish && mres.hit && is_rem) begin
			ram_we    = 1'b1;
			ram_waddr = slot_s2;
			ram_wdata = {1'b0, size_s2, user_s2, base_s2};
		end
	end

	gpat_ram #(
		.WIDTH (RW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (idx_q),
		.rdata (entry_s1)
	);

	gpat_match #(
		.SLOTS     (SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.flush         (finish),
		.func          (func_q),
		.user_address  (ua_q),
		.fault_address (fa_q),
		.page          (page_q),
		.page2         (page2_q),
		.page3         (page3_q),
		.vld_s1        (vld_s1),
		.last_s1       (last_s1),
		.slot_s1       (slot_s1),
		.entry_s1      (entry_s1),
		.mres          (mres),
		.slot_s2       (slot_s2),
		.base_s2       (base_s2),
		.user_s2       (user_s2),
		.size_s2       (size_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= PAGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			page_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue && !finish;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						idx_q   <= '0;
						issue_q <= scan_func;
						state_q <= scan_func ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						issue_q <= 1'b0;
						state_q <= ST_DONE;
						if (mres.hit && is_add) begin
							count_q <= count_q + CNTW'(1);
						end else if (mres.hit && is_rem) begin
							count_q <= count_q - CNTW'(1);
						end
					end else if (issue) begin
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		last_s1 <= idx_q == LAST_IDX;
		if (in_acc) begin
			func_q       <= func;
			base_q       <= block_base;
			ua_q         <= user_address;
			size_q       <= request_size;
			fa_q         <= fault_address;
			page2_q      <= {page_q, 1'b0};
			page3_q      <= (PAGE_W + 2)'({page_q, 1'b0}) + (PAGE_W + 2)'(page_q);
			res_status_q <= (func == FUNC_B2U) ? STATUS_OK : STATUS_NOTFOUND;
			res_slot_q   <= '0;
			res_side_q   <= SIDE_NONE;
			res_base_q   <= '0;
			res_user_q   <= '0;
			res_size_q   <= '0;
			res_comp_q   <= (func == FUNC_B2U) ?
				((ADDR_BITS + 1)'(block_base) + (ADDR_BITS + 1)'(page_q)) : '0;
		end else if (finish) begin
			if (mres.hit) begin
				res_status_q <= STATUS_OK;
				res_slot_q   <= slot_s2;
				res_side_q   <= mres.side;
				res_base_q   <= is_add ? base_q : base_s2;
				res_user_q   <= is_add ? ua_q : user_s2;
				res_size_q   <= is_add ? size_q : size_s2;
			end else begin
				res_status_q <= is_add ? STATUS_FULL : STATUS_NOTFOUND;
			end
		end
		if (out_load) begin
			status_q <= res_status_q;
			slot_q   <= SLOT_W'(res_slot_q);
			side_q   <= res_side_q;
			rbase_q  <= res_base_q;
			ruser_q  <= res_user_q;
			rsize_q  <= res_size_q;
			comp_q   <= res_comp_q;
			live_q   <= COUNT_W'(count_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign slot             = slot_q;
	assign guard_side       = side_q;
	assign record_base      = rbase_q;
	assign record_user      = ruser_q;
	assign record_size      = rsize_q;
	assign computed_address = comp_q;
	assign live_count       = live_q;

endmodule

@@ tb/tb_guard_page_allocation_table_core.sv @@
// Self-checking testbench for the guard page allocation table core with its own table predictor.
module tb_guard_page_allocation_table_core
	import gpat_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int AW          = ADDR_BITS_DEF;
	localparam int LIMIT       = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = SLOTS + 8;
	localparam int POOL_MAX    = 256;
	localparam logic [PAGE_W-1:0] PAGE_MAX  = PAGE_W'(1 << 30);
	localparam logic [AW-1:0]     ADDR_ONES = '1;

	typedef struct packed {
		logic [FUNC_W-1:0] fn;
		logic [AW-1:0]     base;
		logic [AW-1:0]     ua;
		logic [SIZE_W-1:0] size;
		logic [AW-1:0]     fa;
	} op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [SIDE_W-1:0]   side;
		logic [AW-1:0]       rbase;
		logic [AW-1:0]       ruser;
		logic [SIZE_W-1:0]   rsize;
		logic [AW:0]         caddr;
		logic [COUNT_W-1:0]  count;
	} rec_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [PAGE_W-1:0]   cfg_data      = PAGE_RESET;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func          = FUNC_ADD;
	logic [AW-1:0]       block_base    = '0;
	logic [AW-1:0]       user_address  = '0;
	logic [SIZE_W-1:0]   request_size  = '0;
	logic [AW-1:0]       fault_address = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [SIDE_W-1:0]   guard_side;
	logic [AW-1:0]       record_base;
	logic [AW-1:0]       record_user;
	logic [SIZE_W-1:0]   record_size;
	logic [AW:0]         computed_address;
	logic [COUNT_W-1:0]  live_count;

	guard_page_allocation_table_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.block_base       (block_base),
		.user_address     (user_address),
		.request_size     (request_size),
		.fault_address    (fault_address),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.slot             (slot),
		.guard_side       (guard_side),
		.record_base      (record_base),
		.record_user      (record_user),
		.record_size      (record_size),
		.computed_address (computed_address),
		.live_count       (live_count)
	);

	// table shadow
	bit                tab_vld[SLOTS];
	logic [AW-1:0]     tab_base[SLOTS];
	logic [AW-1:0]     tab_user[SLOTS];
	logic [SIZE_W-1:0] tab_size[SLOTS];
	int                tab_live = 0;
	logic [PAGE_W-1:0] page_sz  = PAGE_RESET;

	op_t           op_q[$];
	rec_t          want_q[$];
	logic [AW-1:0] ua_pool[$];
	logic [AW-1:0] base_pool[$];
	logic [AW-1:0] cluster = '0;

	int n_in = 0, n_out = 0, n_err = 0, n_cyc = 0, n_pages = 0;
	int n_full = 0, n_left = 0, n_right = 0;
	int hold_asks = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_user(logic [AW-1:0] ua);
		int i, hit;
		hit = -1;
		for (i = SLOTS - 1; i >= 0; i--)
			if (tab_vld[i] && tab_user[i] == ua)
				hit = i;
		return hit;
	endfunction

	function automatic rec_t with_record(rec_t r, int i);
		r.slot  = SLOT_W'(i);
		r.rbase = tab_base[i];
		r.ruser = tab_user[i];
		r.rsize = tab_size[i];
		return r;
	endfunction

	function automatic rec_t table_apply(op_t op);
		rec_t        r;
		int          i, hit;
		logic [63:0] d, pg;
		r = '0;
		r.status = STATUS_NOTFOUND;
		pg = 64'(page_sz);
		hit = -1;
		case (op.fn)
			FUNC_ADD: begin
				for (i = SLOTS - 1; i >= 0; i--)
					if (!tab_vld[i])
						hit = i;
				if (hit < 0) begin
					r.status = STATUS_FULL;
				end else begin
					tab_vld[hit]  = 1'b1;
					tab_base[hit] = op.base;
					tab_user[hit] = op.ua;
					tab_size[hit] = op.size;
					tab_live++;
					r.status = STATUS_OK;
					r = with_record(r, hit);
				end
			end
			FUNC_REMOVE: begin
				hit = find_user(op.ua);
				if (hit >= 0) begin
					tab_vld[hit] = 1'b0;
					tab_live--;
					r.status = STATUS_OK;
					r = with_record(r, hit);
				end
			end
			FUNC_GUARD: begin
				// downward scan so the lowest hitting slot wins
				for (i = SLOTS - 1; i >= 0; i--) begin
					if (tab_vld[i] && op.fa >= tab_base[i]) begin
						d = 64'(op.fa - tab_base[i]);
						if (d < pg) begin
							hit = i;
							r.side = SIDE_LEFT;
						end else if (d >= 2 * pg && d < 3 * pg) begin
							hit = i;
							r.side = SIDE_RIGHT;
						end
					end
				end
				if (hit >= 0) begin
					r.status = STATUS_OK;
					r = with_record(r, hit);
				end
			end
			FUNC_ULOOK: begin
				hit = find_user(op.ua);
				if (hit >= 0) begin
					r.status = STATUS_OK;
					r = with_record(r, hit);
				end
			end
			FUNC_B2U: begin
				r.status = STATUS_OK;
				r.caddr  = (AW + 1)'(op.base) + (AW + 1)'(page_sz);
			end
			default: ;
		endcase
		r.count = COUNT_W'(tab_live);
		return r;
	endfunction

	function automatic logic [AW-1:0] rnd_addr();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[AW-1:0];
	endfunction

	task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic [AW-1:0] base,
			input logic [AW-1:0] ua, input logic [SIZE_W-1:0] size, input logic [AW-1:0] fa);
		op_q.push_back({fn, base, ua, size, fa});
	endtask

	task automatic queue_random(input int n);
		op_t         op;
		int          k, roll, idx, mode_left;
		bit          filling;
		logic [63:0] pg, off;
		pg = 64'(page_sz);
		filling = 1'b1;
		mode_left = 160;
		for (k = 0; k < n; k++) begin
			if (mode_left == 0) begin
				filling = !filling;
				mode_left = filling ? 160 : 110;
			end
			mode_left--;
			op.base = rnd_addr();
			op.ua   = rnd_addr();
			op.size = $urandom;
			op.fa   = rnd_addr();
			roll = $urandom_range(0, 99);
			if (roll < (filling ? 55 : 12))
				op.fn = FUNC_ADD;
			else if (roll < (filling ? 65 : 55))
				op.fn = FUNC_REMOVE;
			else if (roll < 80)
				op.fn = FUNC_GUARD;
			else if (roll < 90)
				op.fn = FUNC_ULOOK;
			else if (roll < 97)
				op.fn = FUNC_B2U;
			else
				op.fn = FUNC_W'($urandom_range(int'(FUNC_B2U) + 1, (1 << FUNC_W) - 1));
			case (op.fn)
				FUNC_ADD: begin
					// packed neighbors share guard pages, some blocks sit at the top
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5:
							op.base = AW'(64'(cluster) + 64'($urandom_range(0, 7)) * pg);
						6: op.base = AW'(64'(ADDR_ONES) - 64'($urandom_range(0, 2)) * pg
							- 64'($urandom_range(0, 3)));
						default: ;
					endcase
					if ($urandom_range(0, 3) == 0)
						op.ua = AW'($urandom_range(0, 15));
					ua_pool.push_back(op.ua);
					base_pool.push_back(op.base);
					if (ua_pool.size() > POOL_MAX)
						void'(ua_pool.pop_front());
					if (base_pool.size() > POOL_MAX)
						void'(base_pool.pop_front());
				end
				FUNC_REMOVE: begin
					if (ua_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
						idx = $urandom_range(0, ua_pool.size() - 1);
						op.ua = ua_pool[idx];
						ua_pool.delete(idx);
					end
				end
				FUNC_ULOOK: begin
					if (ua_pool.size() > 0 && $urandom_range(0, 3) != 0)
						op.ua = ua_pool[$urandom_range(0, ua_pool.size() - 1)];
				end
				FUNC_GUARD: begin
					if (base_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
						idx = $urandom_range(0, base_pool.size() - 1);
						case ($urandom_range(0, 6))
							0: off = 64'(0);
							1: off = pg - 64'(1);
							2: off = 64'($urandom_range(0, pg - 1));
							3: off = 2 * pg + 64'($urandom_range(0, pg - 1));
							4: off = $urandom_range(0, 1) ? 2 * pg : 3 * pg - 64'(1);
							5: off = pg + 64'($urandom_range(0, pg - 1));
							default: off = 3 * pg + 64'($urandom_range(0, 15));
						endcase
						op.fa = AW'(64'(base_pool[idx]) + off);
						if ($urandom_range(0, 9) == 0)
							op.fa = AW'(64'(base_pool[idx]) - 64'(1)
								- 64'($urandom_range(0, 15)));
					end
				end
				FUNC_B2U: begin
					roll = $urandom_range(0, 9);
					if (roll < 2)
						op.base = ADDR_ONES;
					else if (roll < 5 && base_pool.size() > 0)
						op.base = base_pool[$urandom_range(0, base_pool.size() - 1)];
				end
				default: ;
			endcase
			op_q.push_back(op);
		end
	endtask

	task automatic set_page(input logic [PAGE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		page_sz = v;
		n_pages++;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (op_q.size() != 0 || in_valid || want_q.size() != 0);
	endtask

	task automatic flag_field(input string nm, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			n_err++;
			if (n_err <= 10)
				$display("result %0d: %s expected 0x%0h got 0x%0h", n_out, nm, want, got);
		end
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin : op_drive
		op_t nxt;
		int  burst_left, gap_left;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				want_q.push_back(table_apply({func, block_base, user_address, request_size,
					fault_address}));
				n_in++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (op_q.size() > 0) begin
					nxt = op_q.pop_front();
					func          <= nxt.fn;
					block_base    <= nxt.base;
					user_address  <= nxt.ua;
					request_size  <= nxt.size;
					fault_address <= nxt.fa;
					in_valid      <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin : stall_gen
		int hold_left, hold_seen, mode, mode_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
			mode      <= 0;
			mode_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode      <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= ($urandom_range(0, 99) < 70);
				default: out_stall <= (mode_left % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		rec_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, slot, guard_side, record_base, record_user, record_size,
				computed_address, live_count};
			n_out++;
			if (want_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("result %0d: arrived with nothing expected", n_out);
			end else begin
				want = want_q.pop_front();
				flag_field("status", 64'(want.status), 64'(got.status));
				flag_field("slot", 64'(want.slot), 64'(got.slot));
				flag_field("guard_side", 64'(want.side), 64'(got.side));
				flag_field("record_base", 64'(want.rbase), 64'(got.rbase));
				flag_field("record_user", 64'(want.ruser), 64'(got.ruser));
				flag_field("record_size", 64'(want.rsize), 64'(got.rsize));
				flag_field("computed_address", 64'(want.caddr), 64'(got.caddr));
				flag_field("live_count", 64'(want.count), 64'(got.count));
				if (want.status == STATUS_FULL)
					n_full++;
				if (want.side == SIDE_LEFT)
					n_left++;
				if (want.side == SIDE_RIGHT)
					n_right++;
			end
		end
	end

	always @(posedge clk) begin
		n_cyc <= n_cyc + 1;
		if (n_cyc >= LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", n_cyc, want_q.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (p = 0; p < 6; p++) begin
			case (p)
				0: set_page(PAGE_RESET);
				1: set_page(PAGE_W'(1));
				2: set_page(PAGE_MAX);
				3: set_page(PAGE_W'($urandom_range(2, 1 << 20)));
				4: set_page(PAGE_W'($urandom_range(1, 1 << 30)));
				default: set_page(PAGE_RESET);
			endcase
			cluster = rnd_addr() >> 2;
			if (p == 0) begin
				// empty table, extremes, overlapping guards, duplicate users
				queue_op(FUNC_B2U, '0, rnd_addr(), $urandom, rnd_addr());
				queue_op(FUNC_B2U, ADDR_ONES, rnd_addr(), $urandom, rnd_addr());
				queue_op(FUNC_REMOVE, rnd_addr(), '0, $urandom, rnd_addr());
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, '0);
				queue_op(FUNC_ULOOK, rnd_addr(), '0, $urandom, rnd_addr());
				queue_op(FUNC_ADD, '0, '0, '0, rnd_addr());
				queue_op(FUNC_ADD, ADDR_ONES, ADDR_ONES, '1, rnd_addr());
				queue_op(FUNC_ADD, 48'h10000, 48'h5000, 32'd100, rnd_addr());
				queue_op(FUNC_ADD, 48'h12000, 48'h5000, 32'd7, rnd_addr());
				queue_op(FUNC_ULOOK, rnd_addr(), ADDR_ONES, $urandom, rnd_addr());
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'd0);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'd4095);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'd4096);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'd8192);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'd12287);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'd12288);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, ADDR_ONES);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'h12000);
				queue_op(FUNC_GUARD, rnd_addr(), rnd_addr(), $urandom, 48'h14fff);
				queue_op(FUNC_REMOVE, rnd_addr(), 48'h5000, $urandom, rnd_addr());
				queue_op(FUNC_ULOOK, rnd_addr(), 48'h5000, $urandom, rnd_addr());
				queue_op(FUNC_ADD, 48'h20000, 48'd1, 32'd1, rnd_addr());
				queue_op(FUNC_W'(int'(FUNC_B2U) + 1), rnd_addr(), rnd_addr(), $urandom, rnd_addr());
				queue_op(FUNC_W'(int'(FUNC_B2U) + 2), rnd_addr(), rnd_addr(), $urandom, rnd_addr());
				queue_op(FUNC_W'((1 << FUNC_W) - 1), rnd_addr(), rnd_addr(), $urandom, rnd_addr());
				queue_op(FUNC_REMOVE, rnd_addr(), '0, $urandom, rnd_addr());
			end
			queue_random(p == 5 ? 150 : 250);
			if (p == 1)
				hold_asks++;
			wait_idle();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (want_q.size() != 0) begin
			n_err += want_q.size();
			$display("%0d expected results never arrived", want_q.size());
		end
		$display("%0d operations over %0d page sizes, %0d results compared, %0d mismatches",
			n_in, n_pages, n_out, n_err);
		$display("table full %0d times, guard hits %0d left and %0d right, %0d cycles",
			n_full, n_left, n_right, n_cyc);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
